// File: rtl/hjdc_pkg.sv
package hjdc_pkg;

	localparam int CNT_W = 8;
	localparam int CHK_W = 2;
	localparam int ADC_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam int DETECT_PERIOD_DEF = 10;
	localparam int KEY_PERIOD_DEF = 6;
	localparam int DETECT_CHECKS_DEF = 3;
	localparam int KEY_CHECKS_DEF = 3;

	localparam logic [ADC_W-1:0] THREE_POLE_LIMIT_RST = 12'd5;
	localparam logic [ADC_W-1:0] FOUR_POLE_LOW_RST = 12'd1000;
	localparam logic [ADC_W-1:0] FOUR_POLE_HIGH_RST = 12'd3000;
	localparam logic [ADC_W-1:0] ALT_WINDOW_LOW_RST = 12'd180;
	localparam logic [ADC_W-1:0] ALT_WINDOW_HIGH_RST = 12'd200;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_ADC  = 2'd1,
		MODE_USER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CHOICE_THREE  = 2'd0,
		CHOICE_FOUR   = 2'd1,
		CHOICE_TVOUT  = 2'd2,
		CHOICE_KEEP   = 2'd3
	} choice_t;

	typedef enum logic [2:0] {
		DEV_NONE    = 3'd0,
		DEV_THREE   = 3'd1,
		DEV_FOUR    = 3'd2,
		DEV_TVOUT   = 3'd3,
		DEV_UNKNOWN = 3'd4
	} dev_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_WAIT  = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JACK_ACTIVE_LOW  = 3'd0,
		REG_KEY_ACTIVE_LOW   = 3'd1,
		REG_THREE_POLE_LIMIT = 3'd2,
		REG_FOUR_POLE_LOW    = 3'd3,
		REG_FOUR_POLE_HIGH   = 3'd4,
		REG_ALT_WINDOW_LOW   = 3'd5,
		REG_ALT_WINDOW_HIGH  = 3'd6
	} cfg_reg_t;

endpackage

// File: rtl/headset_jack_detect_classifier.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | mode, jack_pin, key_pin, adc_value, adc_ok,
//         |           |                       | user_choice
// out     | output    | out_valid / out_stall | device_type, headset_present, adc_request,
//         |           |                       | mic_bias, key_bias, key_event, key_value,
//         |           |                       | rejected
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low; an input beat goes through the
// input register, then the state update into the result register
// arst_n clears valid flags and block state, loads config reset values; no sweep after reset
// in_stall rises only while the input register and the result register are both full
// and the result beat is held by out_stall
module headset_jack_detect_classifier #(
	parameter int DETECT_PERIOD = hjdc_pkg::DETECT_PERIOD_DEF,
	parameter int KEY_PERIOD = hjdc_pkg::KEY_PERIOD_DEF,
	parameter int DETECT_CHECKS = hjdc_pkg::DETECT_CHECKS_DEF,
	parameter int KEY_CHECKS = hjdc_pkg::KEY_CHECKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic                             jack_pin,
	input  logic                             key_pin,
	input  logic [hjdc_pkg::ADC_W-1:0]       adc_value,
	input  logic                             adc_ok,
	input  logic [1:0]                       user_choice,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       device_type,
	output logic                             headset_present,
	output logic                             adc_request,
	output logic                             mic_bias,
	output logic                             key_bias,
	output logic                             key_event,
	output logic                             key_value,
	output logic                             rejected,
	input  logic                             cfg_we,
	input  logic [hjdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hjdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [hjdc_pkg::CNT_W-1:0] DET_RELOAD = hjdc_pkg::CNT_W'(DETECT_PERIOD);
	localparam logic [hjdc_pkg::CNT_W-1:0] KEY_RELOAD = hjdc_pkg::CNT_W'(KEY_PERIOD);
	localparam logic [hjdc_pkg::CHK_W-1:0] DET_CHK_MAX = hjdc_pkg::CHK_W'(DETECT_CHECKS);
	localparam logic [hjdc_pkg::CHK_W-1:0] KEY_CHK_MAX = hjdc_pkg::CHK_W'(KEY_CHECKS);

	// config
	logic                        jack_active_low_q;
	logic                        key_active_low_q;
	logic [hjdc_pkg::ADC_W-1:0]  three_pole_limit_q;
	logic [hjdc_pkg::ADC_W-1:0]  four_pole_low_q;
	logic [hjdc_pkg::ADC_W-1:0]  four_pole_high_q;
	logic [hjdc_pkg::ADC_W-1:0]  alt_window_low_q;
	logic [hjdc_pkg::ADC_W-1:0]  alt_window_high_q;

	// input register
	logic                        valid_s1;
	logic [1:0]                  mode_s1;
	logic                        jack_pin_s1;
	logic                        key_pin_s1;
	logic [hjdc_pkg::ADC_W-1:0]  adc_value_s1;
	logic                        adc_ok_s1;
	logic [1:0]                  user_choice_s1;

	// block state
	hjdc_pkg::dev_t              type_q;
	hjdc_pkg::phase_t            det_phase_q;
	logic [hjdc_pkg::CHK_W-1:0]  det_chk_q;
	logic [hjdc_pkg::CNT_W-1:0]  det_cnt_q;
	logic                        key_en_q;
	logic                        key_counting_q;
	logic [hjdc_pkg::CHK_W-1:0]  key_chk_q;
	logic [hjdc_pkg::CNT_W-1:0]  key_cnt_q;
	logic                        last_jack_q;
	logic                        last_key_q;
	logic [1:0]                  bias_q;

	// next state
	hjdc_pkg::dev_t              type_d;
	hjdc_pkg::phase_t            det_phase_d;
	logic [hjdc_pkg::CHK_W-1:0]  det_chk_d;
	logic [hjdc_pkg::CNT_W-1:0]  det_cnt_d;
	logic                        key_en_d;
	logic                        key_counting_d;
	logic [hjdc_pkg::CHK_W-1:0]  key_chk_d;
	logic [hjdc_pkg::CNT_W-1:0]  key_cnt_d;
	logic                        last_jack_d;
	logic                        last_key_d;
	logic [1:0]                  bias_d;
	logic                        kev_d;
	logic                        kval_d;
	logic                        rej_d;

	logic                        jack_c;
	logic                        key_c;
	logic                        advance;

	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jack_active_low_q  <= 1'b0;
			key_active_low_q   <= 1'b0;
			three_pole_limit_q <= hjdc_pkg::THREE_POLE_LIMIT_RST;
			four_pole_low_q    <= hjdc_pkg::FOUR_POLE_LOW_RST;
			four_pole_high_q   <= hjdc_pkg::FOUR_POLE_HIGH_RST;
			alt_window_low_q   <= hjdc_pkg::ALT_WINDOW_LOW_RST;
			alt_window_high_q  <= hjdc_pkg::ALT_WINDOW_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hjdc_pkg::REG_JACK_ACTIVE_LOW:  jack_active_low_q  <= cfg_data[0];
				hjdc_pkg::REG_KEY_ACTIVE_LOW:   key_active_low_q   <= cfg_data[0];
				hjdc_pkg::REG_THREE_POLE_LIMIT: three_pole_limit_q <= cfg_data;
				hjdc_pkg::REG_FOUR_POLE_LOW:    four_pole_low_q    <= cfg_data;
				hjdc_pkg::REG_FOUR_POLE_HIGH:   four_pole_high_q   <= cfg_data;
				hjdc_pkg::REG_ALT_WINDOW_LOW:   alt_window_low_q   <= cfg_data;
				hjdc_pkg::REG_ALT_WINDOW_HIGH:  alt_window_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1        <= mode;
			jack_pin_s1    <= jack_pin;
			key_pin_s1     <= key_pin;
			adc_value_s1   <= adc_value;
			adc_ok_s1      <= adc_ok;
			user_choice_s1 <= user_choice;
		end
	end

	assign jack_c = jack_pin_s1 ^ jack_active_low_q;
	assign key_c  = key_pin_s1 ^ key_active_low_q;

	always_comb begin
		type_d         = type_q;
		det_phase_d    = det_phase_q;
		det_chk_d      = det_chk_q;
		det_cnt_d      = det_cnt_q;
		key_en_d       = key_en_q;
		key_counting_d = key_counting_q;
		key_chk_d      = key_chk_q;
		key_cnt_d      = key_cnt_q;
		last_jack_d    = last_jack_q;
		last_key_d     = last_key_q;
		bias_d         = bias_q;
		kev_d          = 1'b0;
		kval_d         = 1'b0;
		rej_d          = 1'b0;
		case (mode_s1)
			hjdc_pkg::MODE_TICK: begin
				// running timers first
				if (det_phase_q == hjdc_pkg::PH_COUNT) begin
					if (det_cnt_q > hjdc_pkg::CNT_W'(1)) begin
						det_cnt_d = det_cnt_q - hjdc_pkg::CNT_W'(1);
					end else if (!jack_c) begin
						det_phase_d = hjdc_pkg::PH_IDLE;
						det_cnt_d   = '0;
					end else if (det_chk_q < DET_CHK_MAX) begin
						det_chk_d = det_chk_q + hjdc_pkg::CHK_W'(1);
						det_cnt_d = DET_RELOAD;
					end else begin
						bias_d[0]   = 1'b1;
						det_chk_d   = '0;
						det_cnt_d   = '0;
						det_phase_d = hjdc_pkg::PH_WAIT;
					end
				end
				if (key_counting_q) begin
					if (key_cnt_q > hjdc_pkg::CNT_W'(1)) begin
						key_cnt_d = key_cnt_q - hjdc_pkg::CNT_W'(1);
					end else if (!(jack_c && key_c)) begin
						key_counting_d = 1'b0;
						key_cnt_d      = '0;
					end else if (key_chk_q < KEY_CHK_MAX) begin
						key_chk_d = key_chk_q + hjdc_pkg::CHK_W'(1);
						key_cnt_d = KEY_RELOAD;
					end else begin
						kev_d          = 1'b1;
						kval_d         = 1'b1;
						key_chk_d      = '0;
						key_cnt_d      = '0;
						key_counting_d = 1'b0;
					end
				end
				// jack edge
				if (jack_c != last_jack_q) begin
					det_phase_d = hjdc_pkg::PH_IDLE;
					det_cnt_d   = '0;
					if (jack_c && !key_en_q) begin
						det_chk_d   = '0;
						det_cnt_d   = DET_RELOAD;
						det_phase_d = hjdc_pkg::PH_COUNT;
					end else if (!jack_c) begin
						type_d         = hjdc_pkg::DEV_NONE;
						key_counting_d = 1'b0;
						key_cnt_d      = '0;
						if (key_en_q) begin
							bias_d[1] = 1'b0;
							key_en_d  = 1'b0;
						end
					end
				end
				// key edge, key_en_d equals key_en_q unless the jack just dropped
				if (key_c != last_key_q && key_en_d) begin
					key_counting_d = 1'b0;
					key_cnt_d      = '0;
					if (jack_c) begin
						key_chk_d = '0;
						if (!key_c) begin
							kev_d  = 1'b1;
							kval_d = 1'b0;
						end else begin
							key_cnt_d      = KEY_RELOAD;
							key_counting_d = 1'b1;
						end
					end
				end
				last_jack_d = jack_c;
				last_key_d  = key_c;
			end
			hjdc_pkg::MODE_ADC: begin
				if (det_phase_q == hjdc_pkg::PH_WAIT) begin
					det_phase_d = hjdc_pkg::PH_IDLE;
					if (last_jack_q) begin
						bias_d[1] = 1'b1;
						if (adc_ok_s1) begin
							if (adc_value_s1 < three_pole_limit_q) begin
								bias_d[1] = 1'b0;
								type_d    = hjdc_pkg::DEV_THREE;
							end else if ((adc_value_s1 < four_pole_high_q &&
							              adc_value_s1 >= four_pole_low_q) ||
							             (adc_value_s1 > alt_window_low_q &&
							              adc_value_s1 < alt_window_high_q)) begin
								key_en_d = 1'b1;
								type_d   = hjdc_pkg::DEV_FOUR;
							end else begin
								bias_d[1] = 1'b0;
								type_d    = hjdc_pkg::DEV_UNKNOWN;
							end
						end
					end else begin
						type_d    = hjdc_pkg::DEV_NONE;
						bias_d[0] = 1'b0;
					end
				end
			end
			hjdc_pkg::MODE_USER: begin
				if (last_jack_q) begin
					if (type_q != hjdc_pkg::DEV_UNKNOWN) begin
						rej_d = 1'b1;
					end else begin
						case (user_choice_s1)
							hjdc_pkg::CHOICE_THREE: type_d = hjdc_pkg::DEV_THREE;
							hjdc_pkg::CHOICE_FOUR: begin
								key_en_d = 1'b1;
								type_d   = hjdc_pkg::DEV_FOUR;
							end
							hjdc_pkg::CHOICE_TVOUT: begin
								type_d    = hjdc_pkg::DEV_TVOUT;
								bias_d[0] = 1'b0;
							end
							default: ;
						endcase
					end
				end else begin
					type_d    = hjdc_pkg::DEV_NONE;
					bias_d[0] = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q         <= hjdc_pkg::DEV_NONE;
			det_phase_q    <= hjdc_pkg::PH_IDLE;
			det_chk_q      <= '0;
			det_cnt_q      <= '0;
			key_en_q       <= 1'b0;
			key_counting_q <= 1'b0;
			key_chk_q      <= '0;
			key_cnt_q      <= '0;
			last_jack_q    <= 1'b0;
			last_key_q     <= 1'b0;
			bias_q         <= 2'b00;
		end else if (advance) begin
			type_q         <= type_d;
			det_phase_q    <= det_phase_d;
			det_chk_q      <= det_chk_d;
			det_cnt_q      <= det_cnt_d;
			key_en_q       <= key_en_d;
			key_counting_q <= key_counting_d;
			key_chk_q      <= key_chk_d;
			key_cnt_q      <= key_cnt_d;
			last_jack_q    <= last_jack_d;
			last_key_q     <= last_key_d;
			bias_q         <= bias_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!(out_valid && out_stall)) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			device_type     <= type_d;
			headset_present <= (type_d == hjdc_pkg::DEV_THREE) ||
			                   (type_d == hjdc_pkg::DEV_FOUR);
			adc_request     <= (det_phase_d == hjdc_pkg::PH_WAIT);
			mic_bias        <= bias_d[0];
			key_bias        <= bias_d[1];
			key_event       <= kev_d;
			key_value       <= kval_d;
			rejected        <= rej_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_key_value_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_value |-> key_event)
		else $error("key level reported without a key event");

	a_reject_keeps_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> device_type != hjdc_pkg::DEV_UNKNOWN && !key_event)
		else $error("refused choice on an unknown type or with a key event");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room downstream");

	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(type_q) && $stable(det_phase_q) && $stable(bias_q))
		else $error("state moved while the result beat was held");
`endif

endmodule
